// ===== hdl/tiex_pkg.sv =====
// ----------------------------------------------------------------------------
// tiex_pkg
// Shared opcodes, operand selectors and types of the toy ISA execute unit.
// ----------------------------------------------------------------------------
package tiex_pkg;

   localparam int DATA_W = 16;

   typedef enum logic [3:0] {
      OP_MOV  = 4'd0,
      OP_ADD  = 4'd1,
      OP_SUB  = 4'd2,
      OP_MUL  = 4'd3,
      OP_DIV  = 4'd4,
      OP_AND  = 4'd5,
      OP_OR   = 4'd6,
      OP_NOT  = 4'd7,
      OP_CMP  = 4'd8,
      OP_JUMP = 4'd9,
      OP_IN   = 4'd10,
      OP_OUT  = 4'd11
   } opcode_type;

   localparam logic [3:0] SEL_IMM     = 4'd0;
   localparam logic [3:0] SEL_MEM_MIN = 4'd5;

   localparam logic [1:0] FLAG_EQ = 2'd0;
   localparam logic [1:0] FLAG_GT = 2'd1;
   localparam logic [1:0] FLAG_LT = 2'd2;

   localparam logic [7:0] JC_ALWAYS = 8'd0;
   localparam logic [7:0] JC_EQ     = 8'd1;
   localparam logic [7:0] JC_GT     = 8'd2;
   localparam logic [7:0] JC_LT     = 8'd3;

   localparam logic [15:0] JUMP_BIAS = 16'd4;

   // serial arithmetic operation
   typedef enum logic [1:0] {
      SOP_MUL = 2'd0,
      SOP_DIV = 2'd1
   } serial_op_type;

   typedef struct packed {
      logic          start;
      serial_op_type op;
   } serial_ctl_type;

   typedef struct packed {
      logic done;
   } serial_sts_type;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'd0,
      ST_READ  = 3'd1,
      ST_WAIT  = 3'd2,
      ST_EXEC  = 3'd3,
      ST_SER   = 3'd4,
      ST_WRITE = 3'd5,
      ST_RESP  = 3'd6
   } state_type;

endpackage

// ===== hdl/tiex_ram.sv =====
// ----------------------------------------------------------------------------
// tiex_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module tiex_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32768
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write one word when enabled and always read one word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== hdl/tiex_serial_alu.sv =====
// ----------------------------------------------------------------------------
// tiex_serial_alu
// Bit-serial multiplier and signed restoring divider, one bit per cycle.
// ----------------------------------------------------------------------------
module tiex_serial_alu (
   input  logic                    clock,
   input  logic                    reset,
   input  tiex_pkg::serial_ctl_type ctl,
   input  logic [15:0]             dst_val,
   input  logic [15:0]             src_val,
   output tiex_pkg::serial_sts_type sts,
   output logic [15:0]             result
);
   import tiex_pkg::*;

   logic        busy_ff, busy_in;
   logic [4:0]  cnt_ff, cnt_in;
   serial_op_type op_ff, op_in;
   logic [15:0] acc_ff, acc_in;     // product or partial remainder
   logic [15:0] sh_ff, sh_in;       // multiplier bits or dividend/quotient
   logic [15:0] opb_ff, opb_in;     // multiplicand or |divisor|
   logic        neg_ff, neg_in;     // quotient sign
   logic        done_ff, done_in;
   logic [16:0] trial;
   logic [15:0] abs_d, abs_s, quo;

   always_comb begin
      abs_d = dst_val[15] ? 16'(-dst_val) : dst_val;
      abs_s = src_val[15] ? 16'(-src_val) : src_val;
      trial = {acc_ff, sh_ff[15]} - {1'b0, opb_ff};
      quo   = neg_ff ? 16'(-sh_ff) : sh_ff;
   end

   // advance one bit per cycle
   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      op_in   = op_ff;
      acc_in  = acc_ff;
      sh_in   = sh_ff;
      opb_in  = opb_ff;
      neg_in  = neg_ff;
      done_in = 1'b0;
      if (ctl.start) begin
         busy_in = 1'b1;
         cnt_in  = 5'd0;
         op_in   = ctl.op;
         acc_in  = '0;
         if (ctl.op == SOP_MUL) begin
            sh_in  = src_val;
            opb_in = dst_val;
         end else begin
            sh_in  = abs_d;
            opb_in = abs_s;
            neg_in = dst_val[15] ^ src_val[15];
         end
      end else if (busy_ff) begin
         if (op_ff == SOP_MUL) begin
            if (sh_ff[0]) begin
               acc_in = acc_ff + opb_ff;
            end
            sh_in  = {1'b0, sh_ff[15:1]};
            opb_in = {opb_ff[14:0], 1'b0};
         end else begin
            if (!trial[16]) begin
               acc_in = trial[15:0];
               sh_in  = {sh_ff[14:0], 1'b1};
            end else begin
               acc_in = {acc_ff[14:0], sh_ff[15]};
               sh_in  = {sh_ff[14:0], 1'b0};
            end
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd15) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
         op_ff   <= SOP_MUL;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
         op_ff   <= op_in;
      end
      acc_ff <= acc_in;
      sh_ff  <= sh_in;
      opb_ff <= opb_in;
      neg_ff <= neg_in;
   end

   assign sts.done = done_ff;
   assign result   = (op_ff == SOP_MUL) ? acc_ff : quo;
endmodule

// ===== hdl/toy_isa_execute_unit.sv =====
// ----------------------------------------------------------------------------
// toy_isa_execute_unit
// Executes one decoded toy ISA instruction per request against a register
// file and a data memory.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  req_    | in        | req_valid / req_stall  | opcode, operand_byte, immediate, in_value
//  rsp_    | out       | rsp_valid / rsp_stall  | out_value, out_valid, div_by_zero,
//          |           |                        | next_ip, compare_flag
//
//  The response is registered after a request is taken and passes through source read,
//  destination read, execute, write and response; mul and nonzero div also pass through
//  the bit-serial unit. One request is in flight at a time; the next is taken the cycle
//  after the response leaves. Synchronous reset clears registers, ip and flag; memory
//  content stays undefined until written. rsp_stall holds the response.
// ----------------------------------------------------------------------------
module toy_isa_execute_unit #(
   parameter int MEM_DEPTH = 32768,
   parameter int REG_COUNT = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [3:0]  req_opcode,
   input  logic [7:0]  req_operand_byte,
   input  logic signed [15:0] req_immediate,
   input  logic signed [15:0] req_in_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic signed [15:0] rsp_out_value,
   output logic        rsp_out_valid,
   output logic        rsp_div_by_zero,
   output logic [15:0] rsp_next_ip,
   output logic [1:0]  rsp_compare_flag
);
   import tiex_pkg::*;

   localparam int AW = $clog2(MEM_DEPTH);

   state_type state_ff, state_in;

   logic [15:0] regs_ff [REG_COUNT];
   logic [15:0] ip_ff, ip_in;
   logic [1:0]  flag_ff, flag_in;

   logic [3:0]  op_ff;
   logic [7:0]  ob_ff;
   logic [15:0] imm_ff, inv_ff;
   logic [15:0] sval_ff, sval_in, dval_ff, dval_in, res_ff, res_in;
   logic        wr_ff, wr_in, wmem_ff, wmem_in, dz_ff, dz_in;
   logic [3:0]  wreg_ff, wreg_in;
   logic [AW-1:0] waddr_ff, waddr_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_ov_ff, rsp_ov_in;
   logic        rsp_oval_ff, rsp_oval_in;
   logic        rsp_dz_ff, rsp_dz_in;

   logic [3:0]  s_sel, d_sel;
   logic [15:0] reg_s, reg_d;
   logic        s_mem, d_mem;
   logic        ram_we;
   logic [AW-1:0] ram_addr;
   logic [15:0] ram_rd, ram_wd;
   serial_ctl_type ser_ctl;
   serial_sts_type ser_sts;
   logic [15:0] ser_res;
   logic [15:0] alu_dst;
   logic        req_acc;
   logic        take;

   assign s_sel = ob_ff[3:0];
   assign d_sel = ob_ff[7:4];
   assign s_mem = s_sel >= SEL_MEM_MIN;
   assign d_mem = d_sel >= SEL_MEM_MIN;

   // read registers, missing ones as zero
   always_comb begin
      reg_s = '0;
      reg_d = '0;
      for (int i = 0; i < REG_COUNT; i++) begin
         if (s_sel == 4'(i)) reg_s = regs_ff[i];
         if (d_sel == 4'(i)) reg_d = regs_ff[i];
      end
   end

   assign req_stall = (state_ff != ST_IDLE) || rsp_valid_ff;
   assign req_acc   = req_valid && !req_stall;

   // destination operand as the serial unit samples it at start
   assign alu_dst = d_mem ? ram_rd : dval_ff;

   tiex_ram #(.WIDTH(DATA_W), .DEPTH(MEM_DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .addr    (ram_addr),
      .wr_data (ram_wd),
      .rd_data (ram_rd)
   );

   tiex_serial_alu u_alu (
      .clock   (clock),
      .reset   (reset),
      .ctl     (ser_ctl),
      .dst_val (alu_dst),
      .src_val (sval_ff),
      .sts     (ser_sts),
      .result  (ser_res)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req_acc) state_in = ST_READ;
         ST_READ:  state_in = ST_WAIT;
         ST_WAIT:  state_in = ST_EXEC;
         ST_EXEC:  state_in = ((op_ff == OP_MUL) ||
                               (op_ff == OP_DIV && sval_ff != '0)) ? ST_SER : ST_WRITE;
         ST_SER:   if (ser_sts.done) state_in = ST_WRITE;
         ST_WRITE: state_in = ST_RESP;
         ST_RESP:  state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // memory port: source read, destination read, write back
   always_comb begin
      ram_we   = 1'b0;
      ram_wd   = res_ff;
      ram_addr = AW'(reg_s);
      case (state_ff)
         ST_READ:  ram_addr = AW'(reg_s);
         ST_WAIT:  ram_addr = AW'(reg_d);
         ST_WRITE: begin
            ram_addr = waddr_ff;
            ram_we   = wr_ff && wmem_ff;
         end
         default:  ram_addr = AW'(reg_s);
      endcase
   end

   // operand collection and execution
   always_comb begin
      sval_in  = sval_ff;
      dval_in  = dval_ff;
      res_in   = res_ff;
      wr_in    = wr_ff;
      wmem_in  = wmem_ff;
      wreg_in  = wreg_ff;
      waddr_in = waddr_ff;
      dz_in    = dz_ff;
      ip_in    = ip_ff;
      flag_in  = flag_ff;
      ser_ctl.start = 1'b0;
      ser_ctl.op    = (op_ff == OP_MUL) ? SOP_MUL : SOP_DIV;
      take = (ob_ff == JC_ALWAYS) || (ob_ff == JC_EQ && flag_ff == FLAG_EQ) ||
             (ob_ff == JC_GT && flag_ff == FLAG_GT) ||
             (ob_ff == JC_LT && flag_ff == FLAG_LT);
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_ov_in    = rsp_ov_ff;
      rsp_oval_in  = rsp_oval_ff;
      rsp_dz_in    = rsp_dz_ff;
      case (state_ff)
         ST_READ: begin
            sval_in = (s_sel == SEL_IMM) ? imm_ff : reg_s;
            dval_in = reg_d;
            wr_in   = 1'b0;
            dz_in   = 1'b0;
            wreg_in = d_sel;
            wmem_in = d_mem;
            waddr_in = AW'(reg_d);
         end
         ST_WAIT: begin
            if (s_mem) sval_in = ram_rd;
         end
         ST_EXEC: begin
            if (d_mem) dval_in = ram_rd;
         end
         default: ;
      endcase
      if (state_ff == ST_EXEC) begin
         // operands: sval_ff final, destination memory word arrives now
         logic [15:0] dv;
         logic signed [15:0] ca, cb;
         dv = d_mem ? ram_rd : dval_ff;
         ca = reg_d;
         cb = sval_ff;
         wr_in = 1'b1;
         case (op_ff)
            OP_MOV: begin
               res_in = sval_ff;
               if (s_sel == SEL_IMM) wmem_in = 1'b0;
            end
            OP_ADD: res_in = dv + sval_ff;
            OP_SUB: res_in = dv - sval_ff;
            OP_MUL: begin
               wr_in = 1'b0;
               ser_ctl.start = 1'b1;
            end
            OP_DIV: begin
               wr_in = 1'b0;
               if (sval_ff == '0) dz_in = 1'b1;
               else ser_ctl.start = 1'b1;
            end
            OP_AND: res_in = {15'd0, (dv != '0) && (sval_ff != '0)};
            OP_OR:  res_in = {15'd0, (dv != '0) || (sval_ff != '0)};
            OP_NOT: begin
               if (s_sel == SEL_IMM) begin
                  wmem_in = 1'b0;
                  res_in  = {15'd0, reg_d == '0};
               end else if (s_mem) begin
                  wmem_in  = 1'b1;
                  waddr_in = AW'(reg_s);
                  res_in   = {15'd0, sval_ff == '0};
               end else begin
                  wr_in = 1'b0;
               end
            end
            OP_CMP: begin
               wr_in = 1'b0;
               if (s_sel == SEL_IMM) begin
                  ca = dv;
                  cb = imm_ff;
               end
               flag_in = (ca == cb) ? FLAG_EQ : ((ca > cb) ? FLAG_GT : FLAG_LT);
            end
            OP_JUMP: begin
               wr_in = 1'b0;
               if (take) ip_in = ip_ff + imm_ff - JUMP_BIAS;
            end
            OP_IN:  res_in = inv_ff;
            OP_OUT: begin
               wr_in  = 1'b0;
               res_in = dv;
            end
            default: wr_in = 1'b0;
         endcase
         dval_in = dv;
      end
      if (state_ff == ST_SER && ser_sts.done) begin
         res_in = ser_res;
         wr_in  = 1'b1;
      end
      if (state_ff == ST_RESP) begin
         rsp_valid_in = 1'b1;
         rsp_oval_in  = (op_ff == OP_OUT);
         rsp_ov_in    = (op_ff == OP_OUT) ? res_ff : '0;
         rsp_dz_in    = dz_ff;
      end
   end

   // registers and state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ip_ff        <= '0;
         flag_ff      <= FLAG_EQ;
         rsp_valid_ff <= 1'b0;
         wr_ff        <= 1'b0;
         for (int i = 0; i < REG_COUNT; i++) regs_ff[i] <= '0;
      end else begin
         state_ff     <= state_in;
         ip_ff        <= ip_in;
         flag_ff      <= flag_in;
         rsp_valid_ff <= rsp_valid_in;
         wr_ff        <= wr_in;
         if (state_ff == ST_WRITE && wr_ff && !wmem_ff) begin
            for (int i = 0; i < REG_COUNT; i++) begin
               if (wreg_ff == 4'(i)) regs_ff[i] <= res_ff;
            end
         end
      end
      if (req_acc) begin
         op_ff  <= req_opcode;
         ob_ff  <= req_operand_byte;
         imm_ff <= req_immediate;
         inv_ff <= req_in_value;
      end
      sval_ff     <= sval_in;
      dval_ff     <= dval_in;
      res_ff      <= res_in;
      wmem_ff     <= wmem_in;
      wreg_ff     <= wreg_in;
      waddr_ff    <= waddr_in;
      dz_ff       <= dz_in;
      rsp_ov_ff   <= rsp_ov_in;
      rsp_oval_ff <= rsp_oval_in;
      rsp_dz_ff   <= rsp_dz_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_value    = rsp_ov_ff;
   assign rsp_out_valid    = rsp_oval_ff;
   assign rsp_div_by_zero  = rsp_dz_ff;
   assign rsp_next_ip      = ip_ff;
   assign rsp_compare_flag = flag_ff;
endmodule

// ===== sim/toy_isa_execute_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// toy_isa_execute_unit_tb
// Self-checking bench for the toy ISA execute unit. A shadow of the register
// file, data memory, ip and compare flag predicts each response. Requests run
// through phases of sender idling and receiver stalling.
// ----------------------------------------------------------------------------
module toy_isa_execute_unit_tb;
   import tiex_pkg::*;

   localparam int MEM_DEPTH    = 32768;
   localparam int RANDOM_COUNT = 700;
   localparam int WATCHDOG_MAX = 4000;
   localparam int DRAIN_CYCLES = 60;

   typedef struct {
      logic [3:0]  opcode;
      logic [7:0]  operand_byte;
      logic [15:0] immediate;
      logic [15:0] in_value;
   } request_type;

   typedef struct {
      logic [15:0] out_value;
      logic        out_valid;
      logic        div_by_zero;
      logic [15:0] next_ip;
      logic [1:0]  compare_flag;
   } outcome_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [3:0]  req_opcode;
   logic [7:0]  req_operand_byte;
   logic signed [15:0] req_immediate;
   logic signed [15:0] req_in_value;
   logic        rsp_valid;
   logic        rsp_stall;
   logic signed [15:0] rsp_out_value;
   logic        rsp_out_valid;
   logic        rsp_div_by_zero;
   logic [15:0] rsp_next_ip;
   logic [1:0]  rsp_compare_flag;

   // requests waiting to be driven, outcomes waiting to be seen
   request_type pending_requests[$];
   outcome_type expected_outcomes[$];

   // shadow machine state used for prediction
   logic [15:0] shadow_regs[16];
   logic [15:0] shadow_mem[MEM_DEPTH];
   logic [15:0] shadow_ip;
   logic [1:0]  shadow_flag;

   // generator view: address registers and which words hold data
   logic [15:0] gen_regs[16];
   bit          gen_written[MEM_DEPTH];

   request_type current_request;
   bit          request_taken;
   int          requests_accepted;
   int          requests_total;
   int          outcomes_checked;
   int          outputs_seen;
   int          div_zero_seen;
   int          mismatch_count;
   int          idle_cycles;
   int          phase;
   int          send_idle_pct[4] = '{0, 64, 0, 31};
   int          recv_stall_pct[4] = '{0, 0, 64, 31};

   toy_isa_execute_unit #(
      .MEM_DEPTH(MEM_DEPTH),
      .REG_COUNT(16)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_opcode(req_opcode),
      .req_operand_byte(req_operand_byte),
      .req_immediate(req_immediate),
      .req_in_value(req_in_value),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_out_value(rsp_out_value),
      .rsp_out_valid(rsp_out_valid),
      .rsp_div_by_zero(rsp_div_by_zero),
      .rsp_next_ip(rsp_next_ip),
      .rsp_compare_flag(rsp_compare_flag)
   );

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   // Generator side: a memory word is usable once it has been written
   function automatic bit word_ready(logic [3:0] r);
      return gen_written[gen_regs[r][14:0]];
   endfunction

   // Queue a request if it reads no unwritten word; track writes and addresses
   function automatic bit queue_request(logic [3:0] op, logic [7:0] ob,
                                        logic [15:0] imm, logic [15:0] inv);
      logic [3:0]  s;
      logic [3:0]  d;
      bit          ok;
      request_type r;
      s = ob[3:0];
      d = ob[7:4];
      ok = 1'b1;
      case (op)
         OP_MOV: if (s >= SEL_MEM_MIN) ok = word_ready(s);
         OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_AND, OP_OR: begin
            if (s >= SEL_MEM_MIN && !word_ready(s)) ok = 1'b0;
            if (d >= SEL_MEM_MIN && !word_ready(d)) ok = 1'b0;
         end
         OP_NOT: if (s >= SEL_MEM_MIN) ok = word_ready(s);
         OP_CMP: begin
            if (s == SEL_IMM && d >= SEL_MEM_MIN) ok = word_ready(d);
            if (s >= SEL_MEM_MIN) ok = word_ready(s);
         end
         OP_OUT: if (d >= SEL_MEM_MIN) ok = word_ready(d);
         default: ;
      endcase
      if (!ok) return 1'b0;
      if (d >= SEL_MEM_MIN && (op == OP_IN || (op == OP_MOV && s != SEL_IMM)))
         gen_written[gen_regs[d][14:0]] = 1'b1;
      if (op == OP_MOV && s == SEL_IMM) gen_regs[d] = imm;
      if (op == OP_NOT && s == SEL_IMM) gen_regs[d] = (gen_regs[d] == 0) ? 16'd1 : 16'd0;
      r.opcode = op;
      r.operand_byte = ob;
      r.immediate = imm;
      r.in_value = inv;
      pending_requests.push_back(r);
      return 1'b1;
   endfunction

   function automatic logic [15:0] pick_value();
      case ($urandom_range(0, 7))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'hFFFF;
         3: return 16'h0000;
         4: return 16'($urandom_range(0, 9));
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] pick_address();
      case ($urandom_range(0, 5))
         0: return 16'hFFFF;
         1: return 16'h8000 + 16'($urandom_range(0, 7));
         2: return 16'($urandom);
         default: return 16'($urandom_range(0, 7));
      endcase
   endfunction

   // Predictor helpers over the shadow state
   function automatic logic [14:0] mem_index(logic [3:0] r);
      return shadow_regs[r][14:0];
   endfunction

   function automatic logic [15:0] source_value(logic [3:0] s, logic [15:0] imm);
      if (s == SEL_IMM) return imm;
      if (s < SEL_MEM_MIN) return shadow_regs[s];
      return shadow_mem[mem_index(s)];
   endfunction

   function automatic logic [15:0] dest_value(logic [3:0] d);
      if (d < SEL_MEM_MIN) return shadow_regs[d];
      return shadow_mem[mem_index(d)];
   endfunction

   function automatic void dest_write(logic [3:0] d, logic [15:0] v);
      if (d < SEL_MEM_MIN) shadow_regs[d] = v;
      else shadow_mem[mem_index(d)] = v;
   endfunction

   function automatic logic [1:0] signed_order(logic [15:0] a, logic [15:0] b);
      if (a == b) return FLAG_EQ;
      return ($signed(a) > $signed(b)) ? FLAG_GT : FLAG_LT;
   endfunction

   // Run one instruction on the shadow state and return its outcome
   function automatic outcome_type execute_instruction(request_type r);
      outcome_type o;
      logic [3:0]  s;
      logic [3:0]  d;
      logic [15:0] src;
      int          q;
      bit          take;
      s = r.operand_byte[3:0];
      d = r.operand_byte[7:4];
      o.out_value = '0;
      o.out_valid = 1'b0;
      o.div_by_zero = 1'b0;
      case (r.opcode)
         OP_MOV: begin
            if (s == SEL_IMM) shadow_regs[d] = r.immediate;
            else dest_write(d, source_value(s, r.immediate));
         end
         OP_ADD: dest_write(d, dest_value(d) + source_value(s, r.immediate));
         OP_SUB: dest_write(d, dest_value(d) - source_value(s, r.immediate));
         OP_MUL: dest_write(d, dest_value(d) * source_value(s, r.immediate));
         OP_DIV: begin
            src = source_value(s, r.immediate);
            if (src == 0) begin
               o.div_by_zero = 1'b1;
            end else begin
               q = int'($signed(dest_value(d))) / int'($signed(src));
               dest_write(d, q[15:0]);
            end
         end
         OP_AND: dest_write(d, (dest_value(d) != 0 && source_value(s, r.immediate) != 0)
                               ? 16'd1 : 16'd0);
         OP_OR: dest_write(d, (dest_value(d) != 0 || source_value(s, r.immediate) != 0)
                              ? 16'd1 : 16'd0);
         OP_NOT: begin
            if (s == SEL_IMM)
               shadow_regs[d] = (shadow_regs[d] == 0) ? 16'd1 : 16'd0;
            else if (s >= SEL_MEM_MIN)
               shadow_mem[mem_index(s)] = (shadow_mem[mem_index(s)] == 0) ? 16'd1 : 16'd0;
         end
         OP_CMP: begin
            if (s == SEL_IMM) shadow_flag = signed_order(dest_value(d), r.immediate);
            else shadow_flag = signed_order(shadow_regs[d], source_value(s, r.immediate));
         end
         OP_JUMP: begin
            take = (r.operand_byte == JC_ALWAYS) ||
                   (r.operand_byte == JC_EQ && shadow_flag == FLAG_EQ) ||
                   (r.operand_byte == JC_GT && shadow_flag == FLAG_GT) ||
                   (r.operand_byte == JC_LT && shadow_flag == FLAG_LT);
            if (take) shadow_ip = shadow_ip + r.immediate - JUMP_BIAS;
         end
         OP_IN: dest_write(d, r.in_value);
         OP_OUT: begin
            o.out_value = dest_value(d);
            o.out_valid = 1'b1;
         end
         default: ;
      endcase
      o.next_ip = shadow_ip;
      o.compare_flag = shadow_flag;
      return o;
   endfunction

   task automatic report_mismatch(string field, logic [15:0] got, logic [15:0] want);
      mismatch_count++;
      $display("MISMATCH response %0d: %s got %h, want %h",
               outcomes_checked, field, got, want);
   endtask

   // Driver: present the next request at the falling edge
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct[phase]);
         if (!req_valid || request_taken) begin
            if (pending_requests.size() > 0 &&
                $urandom_range(0, 99) >= send_idle_pct[phase]) begin
               current_request = pending_requests.pop_front();
               req_valid <= 1'b1;
               req_opcode <= current_request.opcode;
               req_operand_byte <= current_request.operand_byte;
               req_immediate <= current_request.immediate;
               req_in_value <= current_request.in_value;
            end else begin
               req_valid <= 1'b0;
            end
         end
         request_taken <= 1'b0;
      end
   end

   // Monitor: predict on request acceptance, check on response acceptance
   always @(posedge clock) begin
      outcome_type want;
      bit          moved;
      moved = 1'b0;
      if (!reset && req_valid && !req_stall) begin
         expected_outcomes.push_back(execute_instruction(current_request));
         requests_accepted++;
         phase = (requests_accepted * 4) / (requests_total + 1);
         request_taken <= 1'b1;
         moved = 1'b1;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         moved = 1'b1;
         if (expected_outcomes.size() == 0) begin
            // response with no request outstanding
            report_mismatch("unexpected response", 16'd1, 16'd0);
         end else begin
            want = expected_outcomes.pop_front();
            if (rsp_out_value !== want.out_value)
               report_mismatch("out_value", rsp_out_value, want.out_value);
            if (rsp_out_valid !== want.out_valid)
               report_mismatch("out_valid", 16'(rsp_out_valid), 16'(want.out_valid));
            if (rsp_div_by_zero !== want.div_by_zero)
               report_mismatch("div_by_zero", 16'(rsp_div_by_zero), 16'(want.div_by_zero));
            if (rsp_next_ip !== want.next_ip)
               report_mismatch("next_ip", rsp_next_ip, want.next_ip);
            if (rsp_compare_flag !== want.compare_flag)
               report_mismatch("compare_flag", 16'(rsp_compare_flag),
                               16'(want.compare_flag));
            if (want.out_valid) outputs_seen++;
            if (want.div_by_zero) div_zero_seen++;
         end
         outcomes_checked++;
      end
      // watchdog: too long without any handshake
      if (reset || moved) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_MAX) begin
         $display("Timeout after %0d idle cycles", idle_cycles);
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      int          added;
      logic [3:0]  op;
      logic [7:0]  ob;
      logic [15:0] imm;
      reset = 1'b1;
      req_valid = 1'b0;
      rsp_stall = 1'b0;
      req_opcode = '0;
      req_operand_byte = '0;
      req_immediate = '0;
      req_in_value = '0;
      request_taken = 1'b0;
      phase = 0;
      mismatch_count = 0;
      requests_accepted = 0;
      outcomes_checked = 0;
      outputs_seen = 0;
      div_zero_seen = 0;
      idle_cycles = 0;
      shadow_ip = '0;
      shadow_flag = FLAG_EQ;
      foreach (shadow_regs[i]) begin
         shadow_regs[i] = '0;
         gen_regs[i] = '0;
      end

      // Directed: addressing, wrap of addresses, each operation and corner
      void'(queue_request(OP_MOV, 8'h50, 16'h0000, 16'h0));
      void'(queue_request(OP_MOV, 8'h60, 16'h8001, 16'h0));
      void'(queue_request(OP_MOV, 8'hF0, 16'hFFFF, 16'h0));
      void'(queue_request(OP_IN, 8'h50, 16'h0, 16'h8000));
      void'(queue_request(OP_IN, 8'h60, 16'h0, 16'h7FFF));
      void'(queue_request(OP_IN, 8'hF0, 16'h0, 16'hFFFF));
      void'(queue_request(OP_MOV, 8'h10, 16'hFFFF, 16'h0));
      void'(queue_request(OP_DIV, 8'h51, 16'h0, 16'h0));
      void'(queue_request(OP_DIV, 8'h20, 16'h0, 16'h0));
      void'(queue_request(OP_ADD, 8'h6F, 16'h0, 16'h0));
      void'(queue_request(OP_SUB, 8'h15, 16'h0, 16'h0));
      void'(queue_request(OP_MUL, 8'h60, 16'h7FFF, 16'h0));
      void'(queue_request(OP_AND, 8'h56, 16'h0, 16'h0));
      void'(queue_request(OP_OR, 8'h30, 16'h0, 16'h0));
      void'(queue_request(OP_NOT, 8'h70, 16'h0, 16'h0));
      void'(queue_request(OP_NOT, 8'h0F, 16'h0, 16'h0));
      void'(queue_request(OP_NOT, 8'h12, 16'h0, 16'h0));
      void'(queue_request(OP_CMP, 8'h50, 16'h7FFF, 16'h0));
      void'(queue_request(OP_JUMP, JC_LT, 16'h0010, 16'h0));
      void'(queue_request(OP_CMP, 8'h16, 16'h0, 16'h0));
      void'(queue_request(OP_JUMP, JC_GT, 16'h8000, 16'h0));
      void'(queue_request(OP_JUMP, JC_EQ, 16'h0003, 16'h0));
      void'(queue_request(OP_JUMP, JC_LT + 8'd1, 16'h0100, 16'h0));
      void'(queue_request(OP_JUMP, JC_ALWAYS, 16'h7FFF, 16'h0));
      void'(queue_request(OP_OUT, 8'hF0, 16'h0, 16'h0));
      void'(queue_request(OP_OUT + 4'd1, 8'hFF, 16'hFFFF, 16'hFFFF));

      // Random: mostly address setup, memory fills and full-range operations
      added = 0;
      while (added < RANDOM_COUNT) begin
         case ($urandom_range(0, 9))
            0, 1: begin
               op = OP_MOV;
               ob = {4'($urandom_range(5, 15)), SEL_IMM};
               imm = pick_address();
            end
            2: begin
               op = OP_IN;
               ob = {4'($urandom_range(5, 15)), 4'($urandom)};
               imm = 16'($urandom);
            end
            3: begin
               op = OP_JUMP;
               ob = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
               imm = pick_value();
            end
            default: begin
               op = 4'($urandom_range(0, 15));
               ob = 8'($urandom);
               imm = pick_value();
            end
         endcase
         if (queue_request(op, ob, imm, pick_value())) added++;
      end
      requests_total = pending_requests.size();

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      wait (pending_requests.size() == 0 && requests_accepted == requests_total &&
            expected_outcomes.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Ran %0d instructions with %0d responses checked", requests_total,
               outcomes_checked);
      $display("Saw %0d output values and %0d zero divisors", outputs_seen, div_zero_seen);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
